/* hw/rtl/slir_pkg.sv */
package slir_pkg;

   localparam int ValueWidth  = 16;
   localparam int IndexWidth  = 6;
   localparam int CountWidth  = 7;
   localparam int CmdWidth    = 2;
   localparam int StatusWidth = 2;

   typedef logic signed [ValueWidth-1:0] value_type;

   typedef enum logic [CmdWidth-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic      insert_en;  // accepted insert, list not full
      logic      remove_en;  // accepted remove, match present
      value_type value;
   } cell_ctl_type;

endpackage

/* hw/rtl/slir_cell.sv */
module slir_cell (
   input  logic                    clock,
   input  slir_pkg::cell_ctl_type  ctl,
   input  logic                    cell_valid,
   input  logic                    read_sel,
   input  logic                    left_gt,
   input  slir_pkg::value_type     left_entry,
   input  slir_pkg::value_type     right_entry,
   output slir_pkg::value_type     entry,
   output logic                    gt,
   output logic                    eq,
   output slir_pkg::value_type     read_data
);
   import slir_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      ge;

   // empty slots count as greater so an insert lands at the top of the list
   assign gt        = !cell_valid || (entry_ff > ctl.value);
   assign eq        = cell_valid && (entry_ff == ctl.value);
   assign ge        = cell_valid && (entry_ff >= ctl.value);
   assign entry     = entry_ff;
   assign read_data = read_sel ? entry_ff : '0;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en && gt) begin
         entry_in = left_gt ? left_entry : ctl.value;
      end else if (ctl.remove_en && ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* hw/rtl/sorted_list_insert_remove_top.sv */
// Sorted list of signed 16-bit values with insert, remove and read commands.
// Input channel (req_): one command per transfer. tuser carries the command
// (insert, remove, read, or an ignored code), tdata the value and the read
// index. Result channel (rsp_): exactly one result per command, in order,
// with status, the entry count after the command and the read value.
// The list is a row of CAPACITY cells. Every cell compares its own entry
// with the command value and looks at its neighbors, so an insert shifts
// larger entries up and a remove closes the gap in the same cycle.
// Latency: the result is valid the cycle after the command transfer.
// Throughput: one command per cycle while rsp_tready is high; the cell row
// updates at once and the result register frees itself whenever rsp_tready is high.
// A command is taken while a result waits, as long as that result is taken
// in the same cycle; if the receiver stalls, req_tready drops and the
// pending result holds still.
// Reset clears the entry count and the result valid; no clearing pass is
// needed, entries at or above the count are never read.
// Full insert, remove of an absent value and a read at or beyond the count
// return an error status and leave the list untouched.
module sorted_list_insert_remove_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] value, [21:16] read_index, [23:22] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [1:0] status, [8:2] count_after,
                                    // [24:9] read_value, [31:25] zero
);
   import slir_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > IndexWidth) ? CW : IndexWidth;

   // input unpacking
   cmd_type                 req_cmd;
   value_type               req_value;
   logic [IndexWidth-1:0]   req_index;
   logic                    req_xfer;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_value = value_type'(req_tdata[15:0]);
   assign req_index = req_tdata[21:16];
   assign req_xfer  = req_tvalid && req_tready;

   // state
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CountWidth-1:0]  rsp_count_ff, rsp_count_in;
   value_type              rsp_value_ff, rsp_value_in;

   // cell row wiring
   cell_ctl_type ctl;
   value_type    entry_w [CAPACITY];
   value_type    rd_w    [CAPACITY];
   logic         gt_w    [CAPACITY];
   logic [CAPACITY-1:0] eq_w;

   logic      full;
   logic      found;
   logic      index_ok;
   value_type rd_any;

   assign full     = (count_ff == CW'(CAPACITY));
   assign found    = |eq_w;
   assign index_ok = (XW'(req_index) < XW'(count_ff));

   assign ctl.insert_en = req_xfer && (req_cmd == CMD_INSERT) && !full;
   assign ctl.remove_en = req_xfer && (req_cmd == CMD_REMOVE) && found;
   assign ctl.value     = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      cell_valid;
      logic      read_sel;
      logic      left_gt;
      value_type left_entry;
      value_type right_entry;

      assign cell_valid = (CW'(i) < count_ff);
      assign read_sel   = (XW'(req_index) == XW'(i));

      if (i == 0) begin : g_first
         assign left_gt    = 1'b0;
         assign left_entry = '0;
      end else begin : g_mid
         assign left_gt    = gt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end

      slir_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_valid  (cell_valid),
         .read_sel    (read_sel),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .gt          (gt_w[i]),
         .eq          (eq_w[i]),
         .read_data   (rd_w[i])
      );
   end

   // at most one cell is selected, the others drive zero
   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | rd_w[i];
      end
   end

   // command decode and result
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      case (req_cmd)
         CMD_INSERT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               count_in = count_ff - CW'(1);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         CMD_READ: begin
            if (index_ok) begin
               rsp_value_in = rd_any;
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         default: begin
         end
      endcase
      rsp_count_in = CountWidth'(count_in);
   end

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_value_ff, rsp_count_ff, rsp_status_ff};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the count");

   a_miss_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == CMD_REMOVE && !found) |=> $stable(count_ff))
      else $error("failed remove changed the count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("error result carries a read value");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import slir_pkg::*;

   localparam int ListDepth   = 64;
   localparam int ResetCycles = 12;
   localparam int CycleLimit  = 100000;
   localparam int RandomItems = 1100;
   localparam int PhaseItems  = 140;   // fill, drain and mixed phases rotate at this length
   localparam int IdlePercent = 7;

   // expected response, same field order as rsp_tdata from the lowest bit up
   typedef struct packed {
      value_type              read_value;
      logic [CountWidth-1:0]  count_after;
      status_type             status;
   } list_result_type;

   // tracks the list as the block should hold it and the responses still owed
   class slir_scoreboard;
      value_type       entries[ListDepth];
      int unsigned     count;
      list_result_type expected_q[$];
      int unsigned     failures;

      function new();
         count    = 0;
         failures = 0;
      endfunction

      // called once per accepted command transfer
      function void note_command(cmd_type cmd, value_type value, logic [IndexWidth-1:0] idx);
         list_result_type res;
         int unsigned     pos;
         int unsigned     i;
         res.status     = ST_OK;
         res.read_value = '0;
         case (cmd)
            CMD_INSERT: begin
               if (count >= ListDepth) begin
                  res.status = ST_FULL;
               end else begin
                  // land after any equal entries
                  pos = count;
                  while (pos > 0 && entries[pos-1] > value) begin
                     entries[pos] = entries[pos-1];
                     pos--;
                  end
                  entries[pos] = value;
                  count++;
               end
            end
            CMD_REMOVE: begin
               pos = count;
               for (i = 0; i < count; i++) begin
                  if (entries[i] == value) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= count) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  for (i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
                  count--;
               end
            end
            CMD_READ: begin
               if (idx < count) res.read_value = entries[idx];
               else res.status = ST_BAD_INDEX;
            end
            default: ;
         endcase
         res.count_after = count[CountWidth-1:0];
         expected_q.push_back(res);
      endfunction

      function void check_result(logic [31:0] word);
         list_result_type        want;
         logic [StatusWidth-1:0] got_status;
         logic [CountWidth-1:0]  got_count;
         logic [ValueWidth-1:0]  got_value;
         got_status = word[1:0];
         got_count  = word[8:2];
         got_value  = word[24:9];
         if (expected_q.size() == 0) begin
            $error("response with no command outstanding: tdata %h", word);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            failures++;
         end
         if (got_count !== want.count_after) begin
            $error("count_after: expected %0d, got %0d", want.count_after, got_count);
            failures++;
         end
         if (got_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, $signed(got_value));
            failures++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [15:0] value, [21:16] read_index, [23:22] zero
   logic [1:0]  req_tuser  = '0;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [1:0] status, [8:2] count_after, [24:9] read_value

   slir_scoreboard sb;
   int unsigned    cycle_count = 0;
   bit             sender_gaps = 1'b1;  // cleared for a stretch of back-to-back commands

   sorted_list_insert_remove_top #(.CAPACITY(ListDepth)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("sorted_list_insert_remove_top: mismatch");
         $finish;
      end
   end

   // response monitor: every transfer on the result side is checked in order
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: random stalls, one long hold-off so the result register backs up
   // and req_tready drops, then a long stretch with no stalls at all
   initial begin : receiver
      int unsigned rx_cycle;
      rx_cycle = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= 300 && rx_cycle < 450) rsp_tready <= 1'b0;
         else if (rx_cycle >= 600 && rx_cycle < 1000) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 99) >= IdlePercent);
      end
   end

   // offer one command and hold it until the transfer happens
   task automatic send_command(input cmd_type cmd, input value_type value,
                               input logic [IndexWidth-1:0] idx);
      int unsigned gap;
      if (sender_gaps && $urandom_range(0, 99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, idx, value};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, value, idx);
   endtask

   // duplicates from a narrow pool, the extremes, and the full range
   function automatic value_type pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return value_type'($signed($urandom_range(0, 7)) - 4);
      if (roll < 40) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            default: return 16'sd0;
         endcase
      end
      return value_type'($urandom);
   endfunction

   // mostly values that are held, so removes actually hit
   function automatic value_type pick_remove_value(int unsigned hit_pct);
      if (sb.count > 0 && $urandom_range(0, 99) < hit_pct)
         return sb.entries[$urandom_range(0, sb.count - 1)];
      return pick_value();
   endfunction

   function automatic logic [IndexWidth-1:0] pick_index();
      if (sb.count > 0 && $urandom_range(0, 99) < 75)
         return IndexWidth'($urandom_range(0, sb.count));
      return IndexWidth'($urandom_range(0, 63));
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned phase;
      int unsigned roll;
      int unsigned ins_pct;
      int unsigned rem_pct;
      int unsigned hit_pct;
      sb = new();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list errors, extremes, duplicates, ignored code
      send_command(CMD_READ,   16'sd0,      6'd0);
      send_command(CMD_REMOVE, 16'sd5,      6'd0);
      send_command(CMD_NOP,    -16'sd1,     6'd63);
      send_command(CMD_INSERT, 16'sd0,      6'd0);
      send_command(CMD_INSERT, 16'sh7fff,   6'd0);
      send_command(CMD_INSERT, 16'sh8000,   6'd0);
      send_command(CMD_INSERT, 16'sd0,      6'd0);
      send_command(CMD_INSERT, -16'sd1,     6'd0);
      send_command(CMD_READ,   16'sd0,      6'd0);
      send_command(CMD_READ,   16'sd0,      6'd4);
      send_command(CMD_READ,   16'sd0,      6'd5);   // index equal to count
      send_command(CMD_READ,   -16'sd1,     6'd63);
      send_command(CMD_REMOVE, 16'sd0,      6'd0);   // first of two equal entries
      send_command(CMD_REMOVE, 16'sd1234,   6'd0);
      send_command(CMD_READ,   16'sd0,      6'd2);
      send_command(CMD_INSERT, 16'sh5555,   6'd42);
      send_command(CMD_INSERT, 16'shaaaa,   6'd21);
      send_command(CMD_REMOVE, 16'sh7fff,   6'd0);
      send_command(CMD_REMOVE, 16'sh8000,   6'd0);
      send_command(CMD_READ,   16'sd0,      6'd0);
      send_command(CMD_NOP,    16'sd0,      6'd0);

      // random: fill to full, drain to empty, mixed traffic, in rotation
      sent = 0;
      while (sent < RandomItems) begin
         phase = (sent / PhaseItems) % 3;
         case (phase)
            0:       begin ins_pct = 75; rem_pct = 10; hit_pct = 70; end
            1:       begin ins_pct = 5;  rem_pct = 80; hit_pct = 90; end
            default: begin ins_pct = 30; rem_pct = 30; hit_pct = 60; end
         endcase
         sender_gaps = !(sent >= 500 && sent < 800);
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // ignored code; does not count as an item
            send_command(CMD_NOP, value_type'($urandom), IndexWidth'($urandom));
         end else begin
            if (roll < 3 + ins_pct)
               send_command(CMD_INSERT, pick_value(), IndexWidth'($urandom));
            else if (roll < 3 + ins_pct + rem_pct)
               send_command(CMD_REMOVE, pick_remove_value(hit_pct), IndexWidth'($urandom));
            else
               send_command(CMD_READ, value_type'($urandom), pick_index());
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // drain, then wait for any stray response
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("sorted_list_insert_remove_top: match");
      end else begin
         $display("sorted_list_insert_remove_top: mismatch");
      end
      $finish;
   end

endmodule
